### hw/rtl/etp_pkg.sv
// ----------------------------------------------------------------------------
// etp_pkg
// Types and constants shared by the event transition profiler modules.
// ----------------------------------------------------------------------------
package etp_pkg;

	// Field widths of the request and response items.
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned ID_W    = 4;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned SIZE_W  = 5;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned CLASS_W = 2;

	// Command codes carried in the cmd field.
	typedef enum logic [CMD_W-1:0] {
		CMD_EVENT     = 2'd0,
		CMD_SET_LIMIT = 2'd1,
		CMD_READ      = 2'd2,
		CMD_CLEAR     = 2'd3
	} cmd_t;

	// Transition classes reported in event_class.
	localparam logic [CLASS_W-1:0] CLS_NONE   = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_NORMAL = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_LATE   = 2'd2;

	// A limit of all ones disables the late check for a pair.
	localparam logic [TIME_W-1:0] NO_LIMIT = '1;

	// One word of the pair table.
	typedef struct packed {
		logic [COUNT_W-1:0] normal;
		logic [COUNT_W-1:0] late;
		logic [TIME_W-1:0]  limit;
	} entry_t;

	// Value of a pair after reset or clear.
	localparam entry_t ENTRY_RESET = '{normal: '0, late: '0, limit: NO_LIMIT};

	// Table port controls.
	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

	// Response payload as produced by the controller.
	typedef struct packed {
		logic [COUNT_W-1:0] normal_count;
		logic [COUNT_W-1:0] late_count;
		logic [TIME_W-1:0]  pair_limit;
		logic [CLASS_W-1:0] event_class;
	} result_t;

endpackage

### hw/rtl/etp_if.sv
// ----------------------------------------------------------------------------
// etp_req_if / etp_rsp_if
// Valid/ready channels for profiler requests and responses.
// ----------------------------------------------------------------------------
interface etp_req_if;
	logic                          valid;
	logic                          ready;
	logic [etp_pkg::CMD_W-1:0]     cmd;
	logic [etp_pkg::ID_W-1:0]      event_id;
	logic [etp_pkg::ID_W-1:0]      from_event;
	logic [etp_pkg::TIME_W-1:0]    time_or_limit;
	logic [etp_pkg::SIZE_W-1:0]    clear_size;

	modport source (
		output valid, cmd, event_id, from_event, time_or_limit, clear_size,
		input  ready
	);
	modport sink (
		input  valid, cmd, event_id, from_event, time_or_limit, clear_size,
		output ready
	);
endinterface

interface etp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [etp_pkg::COUNT_W-1:0]   normal_count;
	logic [etp_pkg::COUNT_W-1:0]   late_count;
	logic [etp_pkg::TIME_W-1:0]    pair_limit;
	logic [etp_pkg::CLASS_W-1:0]   event_class;

	modport source (
		output valid, normal_count, late_count, pair_limit, event_class,
		input  ready
	);
	modport sink (
		input  valid, normal_count, late_count, pair_limit, event_class,
		output ready
	);
endinterface

### hw/rtl/event_transition_profiler.sv
// An event, set-limit or read item reads its pair on accept; its result is loaded into the
// output register once free, with any pair write-back, before the next item is accepted.
// A clear item sweeps min(clear_size, NUM_EVENTS)^2 table words, one a cycle, then answers.
// After reset all NUM_EVENTS^2 table words are swept, with ready low, before the first item.
// A new item is accepted while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
// event_transition_profiler
// Counts normal and late transitions between consecutive event IDs per pair,
// with per-pair time limits held in a single table memory.
// ----------------------------------------------------------------------------
module event_transition_profiler #(
	parameter int unsigned NUM_EVENTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	etp_req_if.sink   req,
	etp_rsp_if.source rsp
);

	localparam int unsigned ADDR_W = 2 * $clog2(NUM_EVENTS);

	etp_pkg::mem_ctl_t   mem_ctl;
	logic [ADDR_W-1:0]   mem_addr;
	etp_pkg::entry_t     mem_wdata;
	etp_pkg::entry_t     mem_rdata;
	etp_pkg::result_t    res;
	logic                res_load;
	logic                slot_free;
	logic                rsp_valid_q;
	etp_pkg::result_t    rsp_q;

	etp_ctrl #(
		.NUM_EVENTS (NUM_EVENTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.slot_free (slot_free),
		.res_load  (res_load),
		.res       (res),
		.mem_ctl   (mem_ctl),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	etp_table #(
		.ADDR_W (ADDR_W)
	) u_table (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Output register: frees the controller from the downstream stall.
	assign slot_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (res_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.normal_count = rsp_q.normal_count;
	assign rsp.late_count   = rsp_q.late_count;
	assign rsp.pair_limit   = rsp_q.pair_limit;
	assign rsp.event_class  = rsp_q.event_class;

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!rsp_valid_q || rsp.ready))
		else $error("result loaded over a pending item");

	// Each accepted item occupies the sequencer and takes ready low.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("item accepted while previous item in flight");

	// The table is never written in the cycle a new item reads it.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.rd |-> !mem_ctl.wr)
		else $error("table read and write in the same cycle");

	// Only defined transition classes are reported.
	a_class_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.event_class == etp_pkg::CLS_NONE ||
			rsp_q.event_class == etp_pkg::CLS_NORMAL ||
			rsp_q.event_class == etp_pkg::CLS_LATE))
		else $error("undefined event class");

endmodule

### hw/rtl/etp_table.sv
// ----------------------------------------------------------------------------
// etp_table
// Single-port pair table holding both counters and the limit of each pair,
// with a registered read port.
// ----------------------------------------------------------------------------
module etp_table #(
	parameter int unsigned ADDR_W = 8
) (
	input  logic                 clk,
	input  etp_pkg::mem_ctl_t    ctl,
	input  logic [ADDR_W-1:0]    addr,
	input  etp_pkg::entry_t      wdata,
	output etp_pkg::entry_t      rdata
);

	localparam int unsigned DEPTH = 2 ** ADDR_W;

	etp_pkg::entry_t mem_q [DEPTH];
	etp_pkg::entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[addr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/etp_ctrl.sv
// ----------------------------------------------------------------------------
// etp_ctrl
// Command sequencer: accepts items, reads the addressed pair, classifies and
// updates it, sweeps the table for clears and after reset.
// ----------------------------------------------------------------------------
module etp_ctrl #(
	parameter int unsigned NUM_EVENTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	etp_req_if.sink              req,
	input  logic                 slot_free,
	output logic                 res_load,
	output etp_pkg::result_t     res,
	output etp_pkg::mem_ctl_t    mem_ctl,
	output logic [2*$clog2(NUM_EVENTS)-1:0] mem_addr,
	output etp_pkg::entry_t      mem_wdata,
	input  etp_pkg::entry_t      mem_rdata
);

	localparam int unsigned IDX_W  = $clog2(NUM_EVENTS);
	localparam int unsigned ADDR_W = 2 * IDX_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR
	} state_t;

	state_t                         state_q;
	etp_pkg::cmd_t                  op_q;
	logic                           hit_q;
	logic [etp_pkg::TIME_W-1:0]     val_q;
	logic [ADDR_W-1:0]              addr_q;
	logic [IDX_W-1:0]               prev_event_q;
	logic [etp_pkg::TIME_W-1:0]     prev_time_q;
	logic                           seen_first_q;
	logic                           init_q;
	logic [IDX_W-1:0]               row_q;
	logic [IDX_W-1:0]               col_q;
	logic [IDX_W-1:0]               last_q;

	etp_pkg::cmd_t                  in_cmd;
	logic                           accept;
	logic                           dst_ok;
	logic                           src_ok;
	logic [IDX_W-1:0]               dst_idx;
	logic [IDX_W-1:0]               src_idx;
	logic [ADDR_W-1:0]              acc_addr;
	logic                           acc_hit;
	logic                           size_zero;
	logic                           size_sat;
	logic                           is_late;
	etp_pkg::entry_t                upd_entry;
	logic [etp_pkg::CLASS_W-1:0]    upd_class;

	// Request decode.
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_cmd    = etp_pkg::cmd_t'(req.cmd);
	assign dst_ok    = 32'(req.event_id) < NUM_EVENTS;
	assign src_ok    = 32'(req.from_event) < NUM_EVENTS;
	assign dst_idx   = IDX_W'(req.event_id);
	assign src_idx   = IDX_W'(req.from_event);
	assign size_zero = (req.clear_size == '0);
	assign size_sat  = 32'(req.clear_size) > NUM_EVENTS;

	// Pair address and whether the item touches the table at all.
	always_comb begin
		acc_addr = {src_idx, dst_idx};
		acc_hit  = 1'b0;
		unique case (in_cmd)
			etp_pkg::CMD_EVENT: begin
				acc_addr = {prev_event_q, dst_idx};
				acc_hit  = dst_ok && seen_first_q;
			end
			etp_pkg::CMD_SET_LIMIT,
			etp_pkg::CMD_READ: begin
				acc_hit  = dst_ok && src_ok;
			end
			etp_pkg::CMD_CLEAR: begin
				acc_hit  = 1'b0;
			end
		endcase
	end

	// Classify and update the pair held in the table read register.
	always_comb begin
		upd_entry = mem_rdata;
		upd_class = etp_pkg::CLS_NONE;
		is_late   = (mem_rdata.limit != etp_pkg::NO_LIMIT) && (val_q >= mem_rdata.limit);
		unique case (op_q)
			etp_pkg::CMD_EVENT: begin
				if (is_late) begin
					upd_entry.late = mem_rdata.late + 16'd1;
					upd_class      = etp_pkg::CLS_LATE;
				end else begin
					upd_entry.normal = mem_rdata.normal + 16'd1;
					upd_class        = etp_pkg::CLS_NORMAL;
				end
			end
			etp_pkg::CMD_SET_LIMIT: begin
				upd_entry.limit = val_q;
			end
			etp_pkg::CMD_READ,
			etp_pkg::CMD_CLEAR: begin
			end
		endcase
	end

	// Result of the current item; zero when the table was not used.
	assign res_load = (state_q == ST_EXEC) && slot_free;
	always_comb begin
		res = '0;
		if (hit_q) begin
			res.normal_count = upd_entry.normal;
			res.late_count   = upd_entry.late;
			res.pair_limit   = upd_entry.limit;
			res.event_class  = upd_class;
		end
	end

	// Table port: read on accept, write back on completion, sweep on clear and after reset.
	always_comb begin
		mem_ctl.rd = accept;
		mem_ctl.wr = 1'b0;
		mem_addr   = acc_addr;
		mem_wdata  = upd_entry;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_EXEC: begin
				mem_addr   = addr_q;
				mem_ctl.wr = res_load && hit_q &&
					((op_q == etp_pkg::CMD_EVENT) || (op_q == etp_pkg::CMD_SET_LIMIT));
			end
			ST_CLEAR: begin
				mem_addr   = {row_q, col_q};
				mem_wdata  = etp_pkg::ENTRY_RESET;
				mem_ctl.wr = 1'b1;
			end
		endcase
	end

	// Sequencer state and per-item registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			op_q         <= etp_pkg::CMD_CLEAR;
			hit_q        <= 1'b0;
			val_q        <= '0;
			addr_q       <= '0;
			prev_event_q <= '0;
			prev_time_q  <= '0;
			seen_first_q <= 1'b0;
			init_q       <= 1'b1;
			row_q        <= '0;
			col_q        <= '0;
			last_q       <= IDX_W'(NUM_EVENTS - 1);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q   <= in_cmd;
						hit_q  <= acc_hit;
						addr_q <= acc_addr;
						if (in_cmd == etp_pkg::CMD_EVENT) begin
							val_q <= req.time_or_limit - prev_time_q;
						end else begin
							val_q <= req.time_or_limit;
						end
						if ((in_cmd == etp_pkg::CMD_EVENT) && dst_ok) begin
							prev_event_q <= dst_idx;
							prev_time_q  <= req.time_or_limit;
							seen_first_q <= 1'b1;
						end
						if (in_cmd == etp_pkg::CMD_CLEAR) begin
							prev_event_q <= '0;
							seen_first_q <= 1'b0;
							row_q        <= '0;
							col_q        <= '0;
							if (size_sat) begin
								last_q <= IDX_W'(NUM_EVENTS - 1);
							end else begin
								last_q <= IDX_W'(req.clear_size - 5'd1);
							end
							state_q <= size_zero ? ST_EXEC : ST_CLEAR;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					if (col_q == last_q) begin
						col_q <= '0;
						if (row_q == last_q) begin
							init_q  <= 1'b0;
							state_q <= init_q ? ST_IDLE : ST_EXEC;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the event transition profiler. A short directed
// sequence covers the pair classes, limit boundaries, time wrap and clears.
// Random event streams with limits, reads and clears follow, under varied
// idling on both channels. A scoreboard predicts every response.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned N_EVENTS     = 16;
	localparam int unsigned RANDOM_ITEMS = 1425;
	localparam int unsigned STALL_LIMIT  = 4000;

	typedef logic [etp_pkg::ID_W-1:0]    id_t;
	typedef logic [etp_pkg::TIME_W-1:0]  tval_t;
	typedef logic [etp_pkg::SIZE_W-1:0]  size_t;
	typedef logic [etp_pkg::COUNT_W-1:0] count_t;

	// One request as it crosses the request channel.
	typedef struct packed {
		etp_pkg::cmd_t cmd;
		id_t           event_id;
		id_t           from_event;
		tval_t         time_or_limit;
		size_t         clear_size;
	} profiler_req_t;

	// Keeps a shadow copy of the pair tables and the expected responses.
	class pair_scoreboard;
		count_t             normal_tab [N_EVENTS][N_EVENTS];
		count_t             late_tab   [N_EVENTS][N_EVENTS];
		tval_t              limit_tab  [N_EVENTS][N_EVENTS];
		id_t                last_event;
		tval_t              last_time;
		bit                 have_last;
		etp_pkg::result_t   pending[$];
		int unsigned        mismatches;

		function new();
			clear_pairs(N_EVENTS);
			last_event = '0;
			last_time  = '0;
			have_last  = 1'b0;
			mismatches = 0;
		endfunction

		// Reset the leading square of pairs to zero counts and no limit.
		function void clear_pairs(int unsigned span);
			for (int i = 0; i < span; i++) begin
				for (int j = 0; j < span; j++) begin
					normal_tab[i][j] = '0;
					late_tab[i][j]   = '0;
					limit_tab[i][j]  = etp_pkg::NO_LIMIT;
				end
			end
		endfunction

		// Apply one accepted request and queue the response it must produce.
		function void note_request(profiler_req_t r);
			etp_pkg::result_t  res;
			int unsigned       span;
			id_t               src;
			id_t               dst;
			tval_t             elapsed;
			tval_t             lim;
			res  = '0;
			span = (r.clear_size > N_EVENTS) ? N_EVENTS : 32'(r.clear_size);
			dst  = r.event_id;
			if (r.cmd == etp_pkg::CMD_CLEAR) begin
				clear_pairs(span);
				have_last  = 1'b0;
				last_event = '0;
			end else if (dst < N_EVENTS) begin
				if (r.cmd == etp_pkg::CMD_EVENT) begin
					// The first event only records where and when it happened.
					if (have_last) begin
						src     = last_event;
						lim     = limit_tab[src][dst];
						elapsed = r.time_or_limit - last_time;
						if (lim != etp_pkg::NO_LIMIT && elapsed >= lim) begin
							late_tab[src][dst] = late_tab[src][dst] + 1'b1;
							res.event_class    = etp_pkg::CLS_LATE;
						end else begin
							normal_tab[src][dst] = normal_tab[src][dst] + 1'b1;
							res.event_class      = etp_pkg::CLS_NORMAL;
						end
						res.normal_count = normal_tab[src][dst];
						res.late_count   = late_tab[src][dst];
						res.pair_limit   = lim;
					end
					have_last  = 1'b1;
					last_time  = r.time_or_limit;
					last_event = dst;
				end else if (r.from_event < N_EVENTS) begin
					src = r.from_event;
					if (r.cmd == etp_pkg::CMD_SET_LIMIT) begin
						limit_tab[src][dst] = r.time_or_limit;
					end
					res.normal_count = normal_tab[src][dst];
					res.late_count   = late_tab[src][dst];
					res.pair_limit   = limit_tab[src][dst];
					res.event_class  = etp_pkg::CLS_NONE;
				end
			end
			pending.push_back(res);
		endfunction

		// Compare one response with the oldest expectation.
		function void check_result(etp_pkg::result_t got);
			etp_pkg::result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Response with none expected: normal %0d late %0d limit %h class %0d",
						got.normal_count, got.late_count, got.pair_limit, got.event_class);
				end
			end else begin
				want = pending.pop_front();
				if (got.normal_count !== want.normal_count || got.late_count !== want.late_count ||
					got.pair_limit !== want.pair_limit || got.event_class !== want.event_class) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch: normal %0d/%0d late %0d/%0d limit %h/%h class %0d/%0d",
							want.normal_count, got.normal_count, want.late_count, got.late_count,
							want.pair_limit, got.pair_limit, want.event_class, got.event_class);
						$display("          (expected/actual)");
					end
				end
			end
		endfunction

		function int unsigned outstanding();
			return pending.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	etp_req_if req_ch ();
	etp_rsp_if rsp_ch ();

	event_transition_profiler #(
		.NUM_EVENTS(N_EVENTS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	pair_scoreboard sb = new();
	int unsigned    send_idle_pct = 32;
	int unsigned    recv_idle_pct = 72;
	int unsigned    stall_cycles  = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Response side: random backpressure and checking of every accepted item.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			sb.check_result('{normal_count: rsp_ch.normal_count, late_count: rsp_ch.late_count,
				pair_limit: rsp_ch.pair_limit, event_class: rsp_ch.event_class});
		end
		rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Watchdog: too long without any item moving on either channel ends the run.
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Present one request after a random gap and hold it until it is taken.
	task automatic send_item(etp_pkg::cmd_t cmd, id_t dst, id_t src, tval_t tval, size_t size);
		profiler_req_t r;
		r = '{cmd: cmd, event_id: dst, from_event: src, time_or_limit: tval, clear_size: size};
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.cmd           <= r.cmd;
		req_ch.event_id      <= r.event_id;
		req_ch.from_event    <= r.from_event;
		req_ch.time_or_limit <= r.time_or_limit;
		req_ch.clear_size    <= r.clear_size;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		sb.note_request(r);
	endtask

	// Stop sending until every queued response has come back.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// Mostly event streams over a few hot events, with limits set near the
	// elapsed times so both classes show up; some reads, clears and noise.
	task automatic send_random_item();
		int unsigned pick;
		id_t         dst;
		id_t         src;
		tval_t       lim;
		tval_t       delta;
		pick = $urandom_range(0, 99);
		dst  = id_t'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15));
		src  = id_t'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15));
		if (pick < 8) begin
			send_item(etp_pkg::cmd_t'($urandom_range(0, 3)), id_t'($urandom()),
				id_t'($urandom()), $urandom(), size_t'($urandom_range(0, 31)));
		end else if (pick < 68) begin
			lim = sb.limit_tab[sb.last_event][dst];
			case ($urandom_range(0, 9))
				0: delta = $urandom();
				1, 2, 3: begin
					// Land just below, on, or just above the pair's limit.
					delta = (lim == etp_pkg::NO_LIMIT) ? $urandom_range(0, 300) :
						lim + $urandom_range(0, 2) - 1;
				end
				default: delta = $urandom_range(0, 300);
			endcase
			send_item(etp_pkg::CMD_EVENT, dst, id_t'($urandom()), sb.last_time + delta,
				size_t'($urandom_range(0, 31)));
		end else if (pick < 82) begin
			case ($urandom_range(0, 9))
				0: lim = etp_pkg::NO_LIMIT;
				1: lim = $urandom();
				2: lim = '0;
				default: lim = $urandom_range(1, 300);
			endcase
			send_item(etp_pkg::CMD_SET_LIMIT, dst, src, lim, size_t'($urandom_range(0, 31)));
		end else if (pick < 97) begin
			send_item(etp_pkg::CMD_READ, dst, src, $urandom(), size_t'($urandom_range(0, 31)));
		end else begin
			// Large clears sweep many words, so keep most of them small.
			send_item(etp_pkg::CMD_CLEAR, id_t'($urandom()), id_t'($urandom()), $urandom(),
				size_t'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) :
					$urandom_range(0, 4)));
		end
	endtask

	// Reset, directed checks, then three random phases with different idling.
	initial begin
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.cmd           <= etp_pkg::CMD_EVENT;
		req_ch.event_id      <= '0;
		req_ch.from_event    <= '0;
		req_ch.time_or_limit <= '0;
		req_ch.clear_size    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Fresh tables, first event, and the time counter wrapping.
		send_item(etp_pkg::CMD_READ, 4'd0, 4'd0, 32'h0, 5'd0);
		send_item(etp_pkg::CMD_EVENT, 4'd0, 4'd0, 32'hFFFF_FFF0, 5'd0);
		send_item(etp_pkg::CMD_SET_LIMIT, 4'd15, 4'd0, 32'h20, 5'd0);
		send_item(etp_pkg::CMD_EVENT, 4'd15, 4'd0, 32'h10, 5'd0);
		// A zero limit makes every transition late, even with no time elapsed.
		send_item(etp_pkg::CMD_SET_LIMIT, 4'd15, 4'd15, 32'h0, 5'd0);
		send_item(etp_pkg::CMD_EVENT, 4'd15, 4'd0, 32'h10, 5'd0);
		// Largest real limit, reached exactly.
		send_item(etp_pkg::CMD_SET_LIMIT, 4'd0, 4'd15, 32'hFFFF_FFFE, 5'd0);
		send_item(etp_pkg::CMD_EVENT, 4'd0, 4'd0, 32'hE, 5'd0);
		// All ones means no limit, even for the largest elapsed time.
		send_item(etp_pkg::CMD_SET_LIMIT, 4'd0, 4'd0, etp_pkg::NO_LIMIT, 5'd0);
		send_item(etp_pkg::CMD_EVENT, 4'd0, 4'd0, 32'hD, 5'd0);
		// Just under a limit counts as normal.
		send_item(etp_pkg::CMD_SET_LIMIT, 4'd5, 4'd0, 32'd100, 5'd0);
		send_item(etp_pkg::CMD_EVENT, 4'd5, 4'd0, 32'hD + 32'd99, 5'd0);
		send_item(etp_pkg::CMD_READ, 4'd15, 4'd15, 32'h0, 5'd0);
		send_item(etp_pkg::CMD_READ, 4'd15, 4'd0, 32'h0, 5'd0);
		// A one-pair clear restarts the event chain but keeps other pairs.
		send_item(etp_pkg::CMD_CLEAR, 4'd0, 4'd0, 32'h0, 5'd1);
		send_item(etp_pkg::CMD_EVENT, 4'd3, 4'd0, 32'h200, 5'd0);
		send_item(etp_pkg::CMD_EVENT, 4'd0, 4'd0, 32'h300, 5'd0);
		send_item(etp_pkg::CMD_READ, 4'd0, 4'd0, 32'h0, 5'd0);
		send_item(etp_pkg::CMD_READ, 4'd15, 4'd15, 32'h0, 5'd0);
		// Empty clear, oversized clear that saturates, then a full-size clear.
		send_item(etp_pkg::CMD_CLEAR, 4'd0, 4'd0, 32'h0, 5'd0);
		send_item(etp_pkg::CMD_EVENT, 4'd7, 4'd0, 32'hFFFF_FFFF, 5'd0);
		send_item(etp_pkg::CMD_CLEAR, 4'd15, 4'd15, 32'hFFFF_FFFF, 5'd31);
		send_item(etp_pkg::CMD_READ, 4'd15, 4'd15, 32'h0, 5'd0);
		send_item(etp_pkg::CMD_CLEAR, 4'd0, 4'd0, 32'h0, 5'd16);
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 32;
					recv_idle_pct = 72;
				end
				1: begin
					send_idle_pct = 72;
					recv_idle_pct = 32;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < RANDOM_ITEMS / 3; k++) begin
				send_random_item();
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

### filelist.f
hw/rtl/etp_pkg.sv
hw/rtl/etp_if.sv
hw/rtl/etp_table.sv
hw/rtl/etp_ctrl.sv
hw/rtl/event_transition_profiler.sv
sim/testbench.sv
